// ===== rtl/i2cms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and sizes of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // default transmit store depth
    localparam int BUF_DEPTH_DEF = 16;

    // width of the byte position counter (counts reach at most 31)
    localparam int IDX_W = 5;

    // request kinds
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_EVENT = 2'd3;

    // only the top five status bits carry the code
    localparam logic [7:0] STATUS_MASK = 8'hF8;

    // bus engine status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
    localparam logic [7:0] ST_DATW_ACK   = 8'h28;
    localparam logic [7:0] ST_DATW_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST   = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK  = 8'h48;
    localparam logic [7:0] ST_DATR_ACK   = 8'h50;
    localparam logic [7:0] ST_DATR_NACK  = 8'h58;

    // completion codes
    localparam logic [1:0] DONE_NONE  = 2'd0;
    localparam logic [1:0] DONE_WRITE = 2'd1;
    localparam logic [1:0] DONE_READ  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_ADDR_NACK = 3'd1;
    localparam logic [2:0] ERR_DATA_NACK = 3'd2;
    localparam logic [2:0] ERR_ARB_LOST  = 3'd3;
    localparam logic [2:0] ERR_BUSY      = 3'd4;

    // one input request
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] dev_addr;
        logic [4:0] count;
        logic [3:0] slot;
        logic [7:0] data;
        logic [7:0] status;
    } item_t;

    // one result
    typedef struct packed {
        logic       send_start;
        logic       send_stop;
        logic       byte_valid;
        logic [7:0] tx_byte;
        logic       ack_enable;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic [1:0] done_res;
        logic [2:0] error;
    } result_t;

    // store write port
    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_slot;
        logic [7:0] wr_data;
    } store_wr_t;

endpackage

// ===== rtl/i2cms_tx_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_tx_store
// Transmit byte store: one write port, registered read that follows the byte
// position held after each clock edge.
// ----------------------------------------------------------------------------
module i2cms_tx_store #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  logic                         aclk,
    input  i2cms_pkg::store_wr_t         wr,
    input  logic [i2cms_pkg::IDX_W-1:0]  rd_idx,
    output logic [7:0]                   rd_data
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int IW = i2cms_pkg::IDX_W;

    logic [7:0]                          mem_reg [BUF_DEPTH];
    logic [7:0]                          rd_data_reg;
    logic [AW+3:0]                       wr_wide;
    logic [AW-1:0]                       wr_addr;
    logic [AW+i2cms_pkg::IDX_W-1:0]      rd_wide;
    logic [AW-1:0]                       rd_addr;
    logic                                wr_ok;
    logic                                rd_ok;
    logic                                wr_hit;

    // map slot and position onto the address width
    assign wr_wide = {{AW{1'b0}}, wr.wr_slot};
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_wide = {{AW{1'b0}}, rd_idx};
    assign rd_addr = rd_wide[AW-1:0];

    // only existing entries are written or read
    assign wr_ok  = wr.wr_en && (32'(wr.wr_slot) < BUF_DEPTH);
    assign rd_ok  = 32'(rd_idx) < BUF_DEPTH;
    assign wr_hit = wr_ok && (IW'(wr.wr_slot) == rd_idx);

    // byte writes
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem_reg[wr_addr] <= wr.wr_data;
        end
    end

    // registered read, a byte written in the same cycle passes straight through,
    // positions past the end read as zero
    always_ff @(posedge aclk) begin
        if (!rd_ok) begin
            rd_data_reg <= 8'h00;
        end else if (wr_hit) begin
            rd_data_reg <= wr.wr_data;
        end else begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2cms_seq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_seq_core
// Transaction state and the single-pass decision logic for one request.
// ----------------------------------------------------------------------------
module i2cms_seq_core #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  i2cms_pkg::item_t    item,
    output i2cms_pkg::result_t  res
);

    localparam int IW = i2cms_pkg::IDX_W;
    // largest count a request may take
    localparam logic [IW-1:0] DEPTH_CAP = (BUF_DEPTH > 31) ? 5'd31 : IW'(BUF_DEPTH);

    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [7:0]    target_byte_reg, target_byte_next;
    logic [IW-1:0] write_total_reg, write_total_next;
    logic [IW-1:0] read_total_reg, read_total_next;
    logic          read_mode_reg, read_mode_next;
    logic          busy_reg, busy_next;
    logic          ack_on_reg, ack_on_next;

    i2cms_pkg::store_wr_t store_wr;
    logic [7:0]           store_byte;
    logic [IW-1:0]        rd_idx;
    logic [7:0]           st;
    logic [IW-1:0]        cnt_sat;
    logic [IW-1:0]        bi_inc;
    logic [IW:0]          bi_inc2;

    i2cms_tx_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_tx_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_idx  (rd_idx),
        .rd_data (store_byte)
    );

    // store read follows the byte position that holds after this edge
    assign rd_idx = !aresetn ? '0 : (fire ? byte_index_next : byte_index_reg);

    // store writes: loads and the register byte of a read
    always_comb begin
        store_wr.wr_en   = fire && ((item.op == i2cms_pkg::OP_LOAD) ||
                                    (item.op == i2cms_pkg::OP_READ));
        store_wr.wr_slot = (item.op == i2cms_pkg::OP_READ) ? 4'd0 : item.slot;
        store_wr.wr_data = item.data;
    end

    assign st      = item.status & i2cms_pkg::STATUS_MASK;
    assign cnt_sat = (item.count > DEPTH_CAP) ? DEPTH_CAP : item.count;
    assign bi_inc  = byte_index_reg + 1'b1;
    assign bi_inc2 = {1'b0, bi_inc} + 1'b1;

    // next state and result
    always_comb begin
        byte_index_next  = byte_index_reg;
        target_byte_next = target_byte_reg;
        write_total_next = write_total_reg;
        read_total_next  = read_total_reg;
        read_mode_next   = read_mode_reg;
        busy_next        = busy_reg;
        ack_on_next      = ack_on_reg;
        res              = '0;

        unique case (item.op)
            i2cms_pkg::OP_LOAD: begin
            end
            i2cms_pkg::OP_WRITE: begin
                if (busy_reg) begin
                    res.error = i2cms_pkg::ERR_BUSY;
                end else begin
                    busy_next        = 1'b1;
                    read_mode_next   = 1'b0;
                    target_byte_next = {item.dev_addr, 1'b0};
                    write_total_next = cnt_sat;
                    byte_index_next  = '0;
                    ack_on_next      = 1'b1;
                    res.send_start   = 1'b1;
                end
            end
            i2cms_pkg::OP_READ: begin
                busy_next        = 1'b1;
                read_mode_next   = 1'b1;
                target_byte_next = {item.dev_addr, 1'b0};
                write_total_next = IW'(1);
                read_total_next  = (cnt_sat == '0) ? IW'(1) : cnt_sat;
                byte_index_next  = '0;
                ack_on_next      = 1'b1;
                res.send_start   = 1'b1;
            end
            i2cms_pkg::OP_EVENT: begin
                if (busy_reg) begin
                    unique case (st)
                        i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                            res.byte_valid  = 1'b1;
                            res.tx_byte     = target_byte_reg;
                            byte_index_next = '0;
                        end
                        i2cms_pkg::ST_ARB_LOST: begin
                            res.error       = i2cms_pkg::ERR_ARB_LOST;
                            busy_next       = 1'b0;
                            byte_index_next = '0;
                            ack_on_next     = 1'b1;
                        end
                        i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_DATW_ACK: begin
                            if (byte_index_reg >= write_total_reg) begin
                                if (read_mode_reg) begin
                                    target_byte_next = target_byte_reg | 8'h01;
                                    res.send_start   = 1'b1;
                                end else begin
                                    res.send_stop   = 1'b1;
                                    res.done_res    = i2cms_pkg::DONE_WRITE;
                                    busy_next       = 1'b0;
                                    byte_index_next = '0;
                                    ack_on_next     = 1'b1;
                                end
                            end else begin
                                res.byte_valid  = 1'b1;
                                res.tx_byte     = store_byte;
                                byte_index_next = bi_inc;
                            end
                        end
                        i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_SLAR_NACK: begin
                            res.error = i2cms_pkg::ERR_ADDR_NACK;
                        end
                        i2cms_pkg::ST_DATW_NACK: begin
                            res.error       = i2cms_pkg::ERR_DATA_NACK;
                            busy_next       = 1'b0;
                            byte_index_next = '0;
                            ack_on_next     = 1'b1;
                        end
                        i2cms_pkg::ST_SLAR_ACK: begin
                            if (read_total_reg == IW'(1)) begin
                                ack_on_next = 1'b0;
                            end
                        end
                        i2cms_pkg::ST_DATR_ACK, i2cms_pkg::ST_DATR_NACK: begin
                            if (read_mode_reg && (byte_index_reg < read_total_reg)) begin
                                res.rx_valid    = 1'b1;
                                res.rx_byte     = item.data;
                                res.rx_index    = byte_index_reg[3:0];
                                byte_index_next = bi_inc;
                                if (bi_inc2 == {1'b0, read_total_reg}) begin
                                    ack_on_next = 1'b0;
                                end
                                // last byte closes the read
                                if (bi_inc == read_total_reg) begin
                                    res.send_stop   = 1'b1;
                                    res.done_res    = i2cms_pkg::DONE_READ;
                                    busy_next       = 1'b0;
                                    byte_index_next = '0;
                                    ack_on_next     = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        res.ack_enable = ack_on_next;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg  <= '0;
            target_byte_reg <= '0;
            write_total_reg <= '0;
            read_total_reg  <= '0;
            read_mode_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            ack_on_reg      <= 1'b1;
        end else if (fire) begin
            byte_index_reg  <= byte_index_next;
            target_byte_reg <= target_byte_next;
            write_total_reg <= write_total_next;
            read_total_reg  <= read_total_next;
            read_mode_reg   <= read_mode_next;
            busy_reg        <= busy_next;
            ack_on_reg      <= ack_on_next;
        end
    end

endmodule

// ===== rtl/i2c_master_transaction_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Drives I2C master writes and register reads over a byte-level bus engine.
// ----------------------------------------------------------------------------
//
//  channel | direction | carries
//  --------+-----------+------------------------------------------------------
//  s_      | in        | request: load byte, start write/read, bus status
//  m_      | out       | one result per request: bus commands, rx byte, flags
//
//  A request is registered on entry, decided in one pass, and its result
//  is registered on exit: m_tvalid rises as it enters the result register.
//  One request per cycle is sustained while m_tready stays high.
//  Stalls on m_ hold the result register; the input register then fills and
//  s_tready drops. aresetn is synchronous and clears both valid flags and
//  the transaction state; the transmit store is not cleared.
//
module i2c_master_transaction_sequencer #(
    parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // dev_addr[6:0], count[11:7], slot[15:12],
                                  // data[23:16], status[31:24]
    input  logic [1:0]  s_tuser,  // op[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // send_start[0], send_stop[1], byte_valid[2],
                                  // tx_byte[10:3], ack_enable[11], rx_valid[12],
                                  // rx_byte[20:13], rx_index[24:21],
                                  // done_res[26:25], error[29:27], zero[31:30]
);

    logic                in_valid_reg;
    i2cms_pkg::item_t    in_item_reg;
    logic                out_valid_reg;
    i2cms_pkg::result_t  out_res_reg;
    i2cms_pkg::result_t  res;
    logic                fire;

    // request moves on when the result slot is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op       <= s_tuser;
            in_item_reg.dev_addr <= s_tdata[6:0];
            in_item_reg.count    <= s_tdata[11:7];
            in_item_reg.slot     <= s_tdata[15:12];
            in_item_reg.data     <= s_tdata[23:16];
            in_item_reg.status   <= s_tdata[31:24];
        end
    end

    i2cms_seq_core #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.error,
                       out_res_reg.done_res,
                       out_res_reg.rx_index,
                       out_res_reg.rx_byte,
                       out_res_reg.rx_valid,
                       out_res_reg.ack_enable,
                       out_res_reg.tx_byte,
                       out_res_reg.byte_valid,
                       out_res_reg.send_stop,
                       out_res_reg.send_start};

endmodule

// ===== rtl/i2cms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // completion and error never come together
    a_done_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[26:25] != i2cms_pkg::DONE_NONE)
            |-> m_tdata[29:27] == i2cms_pkg::ERR_NONE)
        else $error("completion reported with an error");

    // rx fields are zero without a received byte
    a_rx_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[12] |-> m_tdata[24:13] == 12'd0)
        else $error("rx fields set without rx_valid");

    // a finished read always closes with a stop and carries a byte
    a_read_done_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[26:25] == i2cms_pkg::DONE_READ) |-> m_tdata[1] && m_tdata[12])
        else $error("read completion without stop or byte");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
